@@ src/nmrb_pkg.sv @@
// ----------------------------------------------------------------------------
// nmrb_pkg: shared constants for the nearest marker range and bearing block
// Widths that do not vary, register indexes, angle constants and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package nmrb_pkg;

    localparam int ID_W      = 16;
    localparam int ANGLE_W   = 16;
    localparam int Z_W       = 32;
    localparam int CFG_IDX_W = 3;
    localparam int PRESCALE  = 8;
    localparam int ATAN_ENTRIES = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROBOT_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE = 3'd3;

    localparam logic [Z_W-1:0] ANGLE_QUARTER       = 32'h4000_0000;
    localparam logic [Z_W-1:0] ANGLE_THREE_QUARTER = 32'hC000_0000;
    localparam logic [Z_W-1:0] ROUND_HALF          = 32'h0000_8000;

    // atan(2^-i) as a 32-bit binary angle, rounded to nearest.
    function automatic logic [Z_W-1:0] nmrb_atan(input int step);
        logic [Z_W-1:0] val;
        case (step)
            0:       val = 32'h20000000;
            1:       val = 32'h12E4051E;
            2:       val = 32'h09FB385B;
            3:       val = 32'h051111D4;
            4:       val = 32'h028B0D43;
            5:       val = 32'h0145D7E1;
            6:       val = 32'h00A2F61E;
            7:       val = 32'h00517C55;
            8:       val = 32'h0028BE53;
            9:       val = 32'h00145F2F;
            10:      val = 32'h000A2F98;
            11:      val = 32'h000517CC;
            12:      val = 32'h00028BE6;
            13:      val = 32'h000145F3;
            14:      val = 32'h0000A2FA;
            15:      val = 32'h0000517D;
            16:      val = 32'h000028BE;
            17:      val = 32'h0000145F;
            18:      val = 32'h00000A30;
            19:      val = 32'h00000518;
            20:      val = 32'h0000028C;
            21:      val = 32'h00000146;
            22:      val = 32'h000000A3;
            23:      val = 32'h00000051;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

@@ src/nmrb_in_if.sv @@
// ----------------------------------------------------------------------------
// nmrb_in_if: marker input channel
// Valid/ready channel that carries one marker per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface nmrb_in_if
    import nmrb_pkg::*;
#(
    parameter int POS_BITS = 24
);
    logic                       valid;
    logic                       ready;
    logic [ID_W-1:0]            marker_id;
    logic signed [POS_BITS-1:0] marker_x;
    logic signed [POS_BITS-1:0] marker_y;
    logic                       scan_end;

    modport source (output valid, marker_id, marker_x, marker_y, scan_end, input ready);
    modport sink   (input valid, marker_id, marker_x, marker_y, scan_end, output ready);
endinterface

`default_nettype wire

@@ src/nmrb_out_if.sv @@
// ----------------------------------------------------------------------------
// nmrb_out_if: result output channel
// Valid/ready channel that carries one marker result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface nmrb_out_if
    import nmrb_pkg::*;
#(
    parameter int POS_BITS = 24
);
    logic                       valid;
    logic                       ready;
    logic [ID_W-1:0]            echo_id;
    logic                       in_range;
    logic signed [POS_BITS:0]   offset_x;
    logic signed [POS_BITS:0]   offset_y;
    logic signed [ANGLE_W-1:0]  bearing;
    logic                       last_flag;
    logic                       closest_found;
    logic [ID_W-1:0]            closest_id;
    logic signed [POS_BITS:0]   closest_x;
    logic signed [POS_BITS:0]   closest_y;
    logic signed [ANGLE_W-1:0]  closest_bearing;

    modport source (
        output valid, echo_id, in_range, offset_x, offset_y, bearing, last_flag,
               closest_found, closest_id, closest_x, closest_y, closest_bearing,
        input  ready
    );
    modport sink (
        input  valid, echo_id, in_range, offset_x, offset_y, bearing, last_flag,
               closest_found, closest_id, closest_x, closest_y, closest_bearing,
        output ready
    );
endinterface

`default_nettype wire

@@ src/nmrb_front.sv @@
// ----------------------------------------------------------------------------
// nmrb_front: offset, squared distance and CORDIC pre-rotation
// Three registered steps: offset from the robot, squares and quadrant
// pre-rotation, then the distance sum and the range compare.
// ----------------------------------------------------------------------------
`default_nettype none

module nmrb_front
    import nmrb_pkg::*;
#(
    parameter int POS_BITS = 24,
    parameter int CW       = 35
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        advance,
    nmrb_in_if.sink                          marker,
    input  wire logic signed [POS_BITS-1:0]  robot_x,
    input  wire logic signed [POS_BITS-1:0]  robot_y,
    input  wire logic [POS_BITS-2:0]         max_range,
    output logic                             out_valid,
    output logic signed [CW-1:0]             out_x,
    output logic signed [CW-1:0]             out_y,
    output logic [Z_W-1:0]                   out_z,
    output logic [ID_W-1:0]                  out_id,
    output logic                             out_last,
    output logic signed [POS_BITS:0]         out_dx,
    output logic signed [POS_BITS:0]         out_dy,
    output logic [2*POS_BITS+1:0]            out_dist,
    output logic                             out_inr,
    output logic                             out_zero
);
    localparam int OW = POS_BITS + 1;
    localparam int DW = 2 * POS_BITS + 2;
    localparam int RW = 2 * POS_BITS - 2;

    // Offset step
    logic                  a_valid_reg;
    logic [ID_W-1:0]       a_id_reg;
    logic                  a_last_reg;
    logic signed [OW-1:0]  a_dx_reg;
    logic signed [OW-1:0]  a_dy_reg;

    // Square and pre-rotation step
    logic                  b_valid_reg;
    logic [ID_W-1:0]       b_id_reg;
    logic                  b_last_reg;
    logic signed [OW-1:0]  b_dx_reg;
    logic signed [OW-1:0]  b_dy_reg;
    logic [DW-1:0]         b_sqx_reg;
    logic [DW-1:0]         b_sqy_reg;
    logic signed [CW-1:0]  b_x_reg;
    logic signed [CW-1:0]  b_y_reg;
    logic [Z_W-1:0]        b_z_reg;
    logic                  b_zero_reg;

    // Distance step
    logic                  c_valid_reg;
    logic [ID_W-1:0]       c_id_reg;
    logic                  c_last_reg;
    logic signed [OW-1:0]  c_dx_reg;
    logic signed [OW-1:0]  c_dy_reg;
    logic [DW-1:0]         c_dist_reg;
    logic                  c_inr_reg;
    logic signed [CW-1:0]  c_x_reg;
    logic signed [CW-1:0]  c_y_reg;
    logic [Z_W-1:0]        c_z_reg;
    logic                  c_zero_reg;

    logic [RW-1:0]         rsq_reg;
    logic [RW-1:0]         rsq_prod;
    logic signed [OW-1:0]  dx_diff;
    logic signed [OW-1:0]  dy_diff;
    logic signed [2*OW-1:0] sqx_prod;
    logic signed [2*OW-1:0] sqy_prod;
    logic signed [CW-1:0]  ax;
    logic signed [CW-1:0]  ay;
    logic signed [CW-1:0]  rot_x;
    logic signed [CW-1:0]  rot_y;
    logic [Z_W-1:0]        rot_z;
    logic [DW-1:0]         dist_sum;

    assign marker.ready = advance;

    always_comb
    begin
        dx_diff  = {marker.marker_x[POS_BITS-1], marker.marker_x}
                 - {robot_x[POS_BITS-1], robot_x};
        dy_diff  = {marker.marker_y[POS_BITS-1], marker.marker_y}
                 - {robot_y[POS_BITS-1], robot_y};
        rsq_prod = max_range * max_range;
        sqx_prod = a_dx_reg * a_dx_reg;
        sqy_prod = a_dy_reg * a_dy_reg;
        ax = {{(CW-OW-PRESCALE){a_dx_reg[OW-1]}}, a_dx_reg, {PRESCALE{1'b0}}};
        ay = {{(CW-OW-PRESCALE){a_dy_reg[OW-1]}}, a_dy_reg, {PRESCALE{1'b0}}};
        // Vectors in the left half-plane are turned by a quarter turn first.
        if (ax < 0)
        begin
            if (ay >= 0)
            begin
                rot_x = ay;
                rot_y = -ax;
                rot_z = ANGLE_QUARTER;
            end
            else
            begin
                rot_x = -ay;
                rot_y = ax;
                rot_z = ANGLE_THREE_QUARTER;
            end
        end
        else
        begin
            rot_x = ax;
            rot_y = ay;
            rot_z = '0;
        end
        dist_sum = b_sqx_reg + b_sqy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            rsq_reg     <= '0;
        end
        else
        begin
            rsq_reg <= rsq_prod;
            if (advance)
            begin
                a_valid_reg <= marker.valid;
                b_valid_reg <= a_valid_reg;
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_id_reg   <= marker.marker_id;
            a_last_reg <= marker.scan_end;
            a_dx_reg   <= dx_diff;
            a_dy_reg   <= dy_diff;

            b_id_reg   <= a_id_reg;
            b_last_reg <= a_last_reg;
            b_dx_reg   <= a_dx_reg;
            b_dy_reg   <= a_dy_reg;
            b_sqx_reg  <= DW'(sqx_prod);
            b_sqy_reg  <= DW'(sqy_prod);
            b_x_reg    <= rot_x;
            b_y_reg    <= rot_y;
            b_z_reg    <= rot_z;
            b_zero_reg <= (a_dx_reg == '0) && (a_dy_reg == '0);

            c_id_reg   <= b_id_reg;
            c_last_reg <= b_last_reg;
            c_dx_reg   <= b_dx_reg;
            c_dy_reg   <= b_dy_reg;
            c_dist_reg <= dist_sum;
            c_inr_reg  <= dist_sum <= DW'(rsq_reg);
            c_x_reg    <= b_x_reg;
            c_y_reg    <= b_y_reg;
            c_z_reg    <= b_z_reg;
            c_zero_reg <= b_zero_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_x     = c_x_reg;
    assign out_y     = c_y_reg;
    assign out_z     = c_z_reg;
    assign out_id    = c_id_reg;
    assign out_last  = c_last_reg;
    assign out_dx    = c_dx_reg;
    assign out_dy    = c_dy_reg;
    assign out_dist  = c_dist_reg;
    assign out_inr   = c_inr_reg;
    assign out_zero  = c_zero_reg;

endmodule

`default_nettype wire

@@ src/nmrb_cell.sv @@
// ----------------------------------------------------------------------------
// nmrb_cell: one CORDIC vectoring step
// Rotates the vector toward the x axis by atan(2^-STEP), accumulates the
// angle and carries the marker data alongside to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module nmrb_cell
    import nmrb_pkg::*;
#(
    parameter int CW   = 35,
    parameter int SB_W = 121,
    parameter int STEP = 0
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire logic                 in_valid,
    input  wire logic signed [CW-1:0] in_x,
    input  wire logic signed [CW-1:0] in_y,
    input  wire logic [Z_W-1:0]       in_z,
    input  wire logic [SB_W-1:0]      in_sb,
    output logic                      out_valid,
    output logic signed [CW-1:0]      out_x,
    output logic signed [CW-1:0]      out_y,
    output logic [Z_W-1:0]            out_z,
    output logic [SB_W-1:0]           out_sb
);
    localparam logic [Z_W-1:0] ATAN = nmrb_atan(STEP);

    logic                 valid_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic [Z_W-1:0]       z_reg;
    logic [SB_W-1:0]      sb_reg;
    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    logic [Z_W-1:0]       z_next;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    always_comb
    begin
        xs = in_x >>> STEP;
        ys = in_y >>> STEP;
        // A vector on or above the axis turns clockwise.
        if (!in_y[CW-1])
        begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + ATAN;
        end
        else
        begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            z_next = in_z - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            z_reg  <= z_next;
            sb_reg <= in_sb;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_sb    = sb_reg;

endmodule

`default_nettype wire

@@ src/nmrb_track.sv @@
// ----------------------------------------------------------------------------
// nmrb_track: bearing rounding, nearest marker search and output register
// Finishes the bearing, keeps the nearest in-range marker of the scan and
// holds the result beat until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module nmrb_track
    import nmrb_pkg::*;
#(
    parameter int POS_BITS = 24
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [Z_W-1:0]              in_z,
    input  wire logic [ID_W-1:0]             in_id,
    input  wire logic                        in_last,
    input  wire logic signed [POS_BITS:0]    in_dx,
    input  wire logic signed [POS_BITS:0]    in_dy,
    input  wire logic [2*POS_BITS+1:0]       in_dist,
    input  wire logic                        in_inr,
    input  wire logic                        in_zero,
    input  wire logic [ANGLE_W-1:0]          heading,
    output logic                             advance,
    nmrb_out_if.source                       result
);
    localparam int OW = POS_BITS + 1;
    localparam int DW = 2 * POS_BITS + 2;

    logic                 best_valid_reg;
    logic [ID_W-1:0]      best_id_reg;
    logic [DW-1:0]        best_dist_reg;
    logic signed [OW-1:0] best_dx_reg;
    logic signed [OW-1:0] best_dy_reg;
    logic [ANGLE_W-1:0]   best_angle_reg;

    logic                 best_valid_next;
    logic [ID_W-1:0]      best_id_next;
    logic [DW-1:0]        best_dist_next;
    logic signed [OW-1:0] best_dx_next;
    logic signed [OW-1:0] best_dy_next;
    logic [ANGLE_W-1:0]   best_angle_next;

    logic                 out_valid_reg;
    logic [ID_W-1:0]      echo_id_reg;
    logic                 in_range_reg;
    logic signed [OW-1:0] offset_x_reg;
    logic signed [OW-1:0] offset_y_reg;
    logic [ANGLE_W-1:0]   bearing_reg;
    logic                 last_flag_reg;
    logic                 closest_found_reg;
    logic [ID_W-1:0]      closest_id_reg;
    logic signed [OW-1:0] closest_x_reg;
    logic signed [OW-1:0] closest_y_reg;
    logic [ANGLE_W-1:0]   closest_bearing_reg;

    logic [Z_W-1:0]       round_sum;
    logic [ANGLE_W-1:0]   raw_angle;
    logic [ANGLE_W-1:0]   angle;
    logic                 take;
    logic                 report;

    assign advance = !out_valid_reg || result.ready;

    always_comb
    begin
        round_sum = in_z + ROUND_HALF;
        // A marker at the robot position has a raw angle of zero.
        raw_angle = in_zero ? '0 : round_sum[Z_W-1 -: ANGLE_W];
        angle     = raw_angle - heading;

        // Only a strictly smaller distance replaces the current nearest marker.
        take = in_valid && in_inr && (!best_valid_reg || (in_dist < best_dist_reg));
        if (take)
        begin
            best_valid_next = 1'b1;
            best_id_next    = in_id;
            best_dist_next  = in_dist;
            best_dx_next    = in_dx;
            best_dy_next    = in_dy;
            best_angle_next = angle;
        end
        else
        begin
            best_valid_next = best_valid_reg;
            best_id_next    = best_id_reg;
            best_dist_next  = best_dist_reg;
            best_dx_next    = best_dx_reg;
            best_dy_next    = best_dy_reg;
            best_angle_next = best_angle_reg;
        end
        report = in_last && best_valid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid;
            if (in_valid)
            begin
                best_valid_reg <= in_last ? 1'b0 : best_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            best_id_reg    <= best_id_next;
            best_dist_reg  <= best_dist_next;
            best_dx_reg    <= best_dx_next;
            best_dy_reg    <= best_dy_next;
            best_angle_reg <= best_angle_next;

            echo_id_reg         <= in_id;
            in_range_reg        <= in_inr;
            offset_x_reg        <= in_dx;
            offset_y_reg        <= in_dy;
            bearing_reg         <= angle;
            last_flag_reg       <= in_last;
            closest_found_reg   <= report;
            closest_id_reg      <= report ? best_id_next : '0;
            closest_x_reg       <= report ? best_dx_next : '0;
            closest_y_reg       <= report ? best_dy_next : '0;
            closest_bearing_reg <= report ? best_angle_next : '0;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.echo_id         = echo_id_reg;
    assign result.in_range        = in_range_reg;
    assign result.offset_x        = offset_x_reg;
    assign result.offset_y        = offset_y_reg;
    assign result.bearing         = bearing_reg;
    assign result.last_flag       = last_flag_reg;
    assign result.closest_found   = closest_found_reg;
    assign result.closest_id      = closest_id_reg;
    assign result.closest_x       = closest_x_reg;
    assign result.closest_y       = closest_y_reg;
    assign result.closest_bearing = closest_bearing_reg;

endmodule

`default_nettype wire

@@ src/nearest_marker_range_bearing.sv @@
// A marker beat passes the front steps, the CORDIC cells and the output register.
// Throughput: one marker per cycle; the front steps, the row of CORDIC cells and
// the output register all move together and hold while a result beat waits.
// Reset clears the configuration registers, every pipeline valid bit and the
// nearest-marker search; no clearing pass is needed.
// ----------------------------------------------------------------------------
// nearest_marker_range_bearing: marker range, bearing and nearest search
// Computes each marker's offset, range check and CORDIC bearing and reports
// the nearest in-range marker on the last marker of a scan.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_marker_range_bearing
    import nmrb_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int POS_BITS     = 24
)
(
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         cfg_we,
    input  wire logic [CFG_IDX_W-1:0]                         cfg_index,
    input  wire logic [((POS_BITS > ANGLE_W) ? POS_BITS : ANGLE_W)-1:0] cfg_data,
    nmrb_in_if.sink                                           marker,
    nmrb_out_if.source                                        result
);
    localparam int OW   = POS_BITS + 1;
    localparam int DW   = 2 * POS_BITS + 2;
    // Scaled offset plus growth from pre-rotation and CORDIC gain.
    localparam int CW   = POS_BITS + PRESCALE + 3;
    localparam int SB_W = ID_W + 1 + 2 * OW + DW + 2;

    logic signed [POS_BITS-1:0] robot_x_reg;
    logic signed [POS_BITS-1:0] robot_y_reg;
    logic [ANGLE_W-1:0]         heading_reg;
    logic [POS_BITS-2:0]        max_range_reg;

    logic advance;

    logic                 chain_valid [0:CORDIC_STEPS];
    logic signed [CW-1:0] chain_x     [0:CORDIC_STEPS];
    logic signed [CW-1:0] chain_y     [0:CORDIC_STEPS];
    logic [Z_W-1:0]       chain_z     [0:CORDIC_STEPS];
    logic [SB_W-1:0]      chain_sb    [0:CORDIC_STEPS];

    logic [ID_W-1:0]      f_id;
    logic                 f_last;
    logic signed [OW-1:0] f_dx;
    logic signed [OW-1:0] f_dy;
    logic [DW-1:0]        f_dist;
    logic                 f_inr;
    logic                 f_zero;

    logic [ID_W-1:0]      t_id;
    logic                 t_last;
    logic signed [OW-1:0] t_dx;
    logic signed [OW-1:0] t_dy;
    logic [DW-1:0]        t_dist;
    logic                 t_inr;
    logic                 t_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            robot_x_reg   <= '0;
            robot_y_reg   <= '0;
            heading_reg   <= '0;
            max_range_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROBOT_X:   robot_x_reg   <= cfg_data[POS_BITS-1:0];
                CFG_ROBOT_Y:   robot_y_reg   <= cfg_data[POS_BITS-1:0];
                CFG_HEADING:   heading_reg   <= cfg_data[ANGLE_W-1:0];
                CFG_MAX_RANGE: max_range_reg <= cfg_data[POS_BITS-2:0];
                default:       ;
            endcase
        end
    end

    nmrb_front #(
        .POS_BITS (POS_BITS),
        .CW       (CW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .marker    (marker),
        .robot_x   (robot_x_reg),
        .robot_y   (robot_y_reg),
        .max_range (max_range_reg),
        .out_valid (chain_valid[0]),
        .out_x     (chain_x[0]),
        .out_y     (chain_y[0]),
        .out_z     (chain_z[0]),
        .out_id    (f_id),
        .out_last  (f_last),
        .out_dx    (f_dx),
        .out_dy    (f_dy),
        .out_dist  (f_dist),
        .out_inr   (f_inr),
        .out_zero  (f_zero)
    );

    assign chain_sb[0] = {f_id, f_last, f_dx, f_dy, f_dist, f_inr, f_zero};

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        nmrb_cell #(
            .CW   (CW),
            .SB_W (SB_W),
            .STEP (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (chain_valid[i]),
            .in_x      (chain_x[i]),
            .in_y      (chain_y[i]),
            .in_z      (chain_z[i]),
            .in_sb     (chain_sb[i]),
            .out_valid (chain_valid[i+1]),
            .out_x     (chain_x[i+1]),
            .out_y     (chain_y[i+1]),
            .out_z     (chain_z[i+1]),
            .out_sb    (chain_sb[i+1])
        );
    end

    assign {t_id, t_last, t_dx, t_dy, t_dist, t_inr, t_zero} = chain_sb[CORDIC_STEPS];

    nmrb_track #(
        .POS_BITS (POS_BITS)
    ) u_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (chain_valid[CORDIC_STEPS]),
        .in_z     (chain_z[CORDIC_STEPS]),
        .in_id    (t_id),
        .in_last  (t_last),
        .in_dx    (t_dx),
        .in_dy    (t_dy),
        .in_dist  (t_dist),
        .in_inr   (t_inr),
        .in_zero  (t_zero),
        .heading  (heading_reg),
        .advance  (advance),
        .result   (result)
    );

endmodule

`default_nettype wire

@@ verif/nmrb_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmrb_result_checker: scoreboard for the nearest marker range/bearing block
// Watches the register port and both channels. For every marker beat taken
// by the block it works out the offset, range flag, CORDIC bearing and the
// nearest-marker report, queues the result, and compares each result beat
// against the oldest queued result.
// ----------------------------------------------------------------------------

module nmrb_result_checker
    import nmrb_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int POS_BITS     = 24,
    parameter int CFG_W        = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    nmrb_in_if                   marker,
    nmrb_out_if                  result,
    output int                   errors,
    output int                   pending,
    output int                   results_seen,
    output int                   in_range_hits,
    output int                   nearest_hits
);

    localparam int MAX_SHOWN = 10;

    // atan(2^-i) in 32-bit binary angle units, step 0 first.
    localparam logic [ATAN_ENTRIES*Z_W-1:0] ATAN_STEPS = {
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic [ID_W-1:0]           echo_id;
        logic                      in_range;
        logic signed [POS_BITS:0]  offset_x;
        logic signed [POS_BITS:0]  offset_y;
        logic signed [ANGLE_W-1:0] bearing;
        logic                      last_flag;
        logic                      closest_found;
        logic [ID_W-1:0]           closest_id;
        logic signed [POS_BITS:0]  closest_x;
        logic signed [POS_BITS:0]  closest_y;
        logic signed [ANGLE_W-1:0] closest_bearing;
    } marker_result_t;

    // Shadow of the block's registers.
    logic signed [POS_BITS-1:0] robot_x;
    logic signed [POS_BITS-1:0] robot_y;
    logic [ANGLE_W-1:0]         heading;
    logic [POS_BITS-2:0]        max_range;

    // Nearest in-range marker of the scan so far.
    logic               best_valid;
    logic [ID_W-1:0]    best_id;
    longint             best_dsq;
    longint             best_dx;
    longint             best_dy;
    logic [ANGLE_W-1:0] best_brg;

    marker_result_t pending_results[$];
    marker_result_t want;
    marker_result_t got;
    int             fails;
    int             seen;
    int             hits;
    int             found;

    function automatic logic [ANGLE_W-1:0] angle_of(input longint ox, input longint oy);
        longint      cx;
        longint      cy;
        longint      sx;
        longint      sy;
        longint      tmp;
        logic [Z_W-1:0] z;
        int          i;
        if (ox == 0 && oy == 0)
            return '0;
        cx = ox * 256;
        cy = oy * 256;
        z  = '0;
        // Left half-plane vectors are turned a quarter turn first.
        if (cx < 0)
        begin
            tmp = cx;
            if (cy >= 0)
            begin
                cx = cy;
                cy = -tmp;
                z  = ANGLE_QUARTER;
            end
            else
            begin
                cx = -cy;
                cy = tmp;
                z  = ANGLE_THREE_QUARTER;
            end
        end
        for (i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++)
        begin
            sx = cx >>> i;
            sy = cy >>> i;
            if (cy >= 0)
            begin
                cx = cx + sy;
                cy = cy - sx;
                z  = z + ATAN_STEPS[(ATAN_ENTRIES-1-i)*Z_W +: Z_W];
            end
            else
            begin
                cx = cx - sy;
                cy = cy + sx;
                z  = z - ATAN_STEPS[(ATAN_ENTRIES-1-i)*Z_W +: Z_W];
            end
        end
        z = z + ROUND_HALF;
        return z[Z_W-1 -: ANGLE_W];
    endfunction

    function automatic void clear_search();
        best_valid = 1'b0;
        best_id    = '0;
        best_dsq   = 0;
        best_dx    = 0;
        best_dy    = 0;
        best_brg   = '0;
    endfunction

    // Works out one marker's result and advances the nearest-marker search.
    function automatic marker_result_t range_bearing_of(
        input logic [ID_W-1:0]          id,
        input logic signed [POS_BITS-1:0] mx,
        input logic signed [POS_BITS-1:0] my,
        input logic                     last
    );
        marker_result_t     r;
        longint             ox;
        longint             oy;
        longint             dsq;
        longint             rsq;
        logic [ANGLE_W-1:0] brg;
        logic               near;
        ox   = longint'(mx) - longint'(robot_x);
        oy   = longint'(my) - longint'(robot_y);
        dsq  = ox * ox + oy * oy;
        rsq  = longint'(max_range) * longint'(max_range);
        near = (dsq <= rsq);
        brg  = angle_of(ox, oy) - heading;

        // Only a strictly closer marker replaces the current one.
        if (near && (!best_valid || dsq < best_dsq))
        begin
            best_valid = 1'b1;
            best_id    = id;
            best_dsq   = dsq;
            best_dx    = ox;
            best_dy    = oy;
            best_brg   = brg;
        end

        r          = '0;
        r.echo_id  = id;
        r.in_range = near;
        r.offset_x = ox[POS_BITS:0];
        r.offset_y = oy[POS_BITS:0];
        r.bearing  = brg;
        r.last_flag = last;
        if (last && best_valid)
        begin
            r.closest_found   = 1'b1;
            r.closest_id      = best_id;
            r.closest_x       = best_dx[POS_BITS:0];
            r.closest_y       = best_dy[POS_BITS:0];
            r.closest_bearing = best_brg;
        end
        if (last)
            clear_search();
        return r;
    endfunction

    function automatic string describe(input marker_result_t r);
        return $sformatf({"id=%h in=%b dx=%0d dy=%0d brg=%0d last=%b found=%b",
                          " cid=%h cx=%0d cy=%0d cbrg=%0d"},
                         r.echo_id, r.in_range, r.offset_x, r.offset_y, r.bearing,
                         r.last_flag, r.closest_found, r.closest_id, r.closest_x,
                         r.closest_y, r.closest_bearing);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            robot_x   <= '0;
            robot_y   <= '0;
            heading   <= '0;
            max_range <= '0;
            clear_search();
            pending_results.delete();
            fails = 0;
            seen  = 0;
            hits  = 0;
            found = 0;
            errors        <= 0;
            pending       <= 0;
            results_seen  <= 0;
            in_range_hits <= 0;
            nearest_hits  <= 0;
        end
        else
        begin
            // The oldest result is checked before this edge's marker is queued.
            if (result.valid && result.ready)
            begin
                got.echo_id         = result.echo_id;
                got.in_range        = result.in_range;
                got.offset_x        = result.offset_x;
                got.offset_y        = result.offset_y;
                got.bearing         = result.bearing;
                got.last_flag       = result.last_flag;
                got.closest_found   = result.closest_found;
                got.closest_id      = result.closest_id;
                got.closest_x       = result.closest_x;
                got.closest_y       = result.closest_y;
                got.closest_bearing = result.closest_bearing;
                seen++;
                if (pending_results.size() == 0)
                begin
                    if (fails < MAX_SHOWN)
                        $display("%0t: result beat with none outstanding: %s",
                                 $time, describe(got));
                    fails++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (want.in_range)
                        hits++;
                    if (want.closest_found)
                        found++;
                    if (got !== want)
                    begin
                        if (fails < MAX_SHOWN)
                        begin
                            $display("%0t: result mismatch", $time);
                            $display("    expected %s", describe(want));
                            $display("    actual   %s", describe(got));
                        end
                        fails++;
                    end
                end
            end

            if (marker.valid && marker.ready)
                pending_results.insert(pending_results.size(),
                                       range_bearing_of(marker.marker_id, marker.marker_x,
                                                        marker.marker_y, marker.scan_end));

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROBOT_X:   robot_x   <= cfg_data[POS_BITS-1:0];
                    CFG_ROBOT_Y:   robot_y   <= cfg_data[POS_BITS-1:0];
                    CFG_HEADING:   heading   <= cfg_data[ANGLE_W-1:0];
                    CFG_MAX_RANGE: max_range <= cfg_data[POS_BITS-2:0];
                    default:       ;
                endcase
            end

            errors        <= fails;
            pending       <= pending_results.size();
            results_seen  <= seen;
            in_range_hits <= hits;
            nearest_hits  <= found;
        end
    end

endmodule

@@ verif/tb_nearest_marker_range_bearing.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_marker_range_bearing: testbench top for the marker range block
// Drives robot settings and marker scans, first a directed set around the
// axes, extremes, ties and scans with no marker in range, then random
// scans under random settings with random gaps on both channels. The
// checker judges every beat.

module tb_nearest_marker_range_bearing;

    import nmrb_pkg::*;

    localparam int CORDIC_STEPS    = 16;
    localparam int POS_BITS        = 24;
    localparam int CFG_W           = (POS_BITS > ANGLE_W) ? POS_BITS : ANGLE_W;
    localparam int LATENCY         = CORDIC_STEPS + 4;
    localparam int POS_MAX         = (1 << (POS_BITS - 1)) - 1;
    localparam int POS_MIN         = -(1 << (POS_BITS - 1));
    localparam int RANGE_MAX       = POS_MAX;
    localparam int IDLE_PCT        = 26;
    localparam int CALM_LO         = 500;
    localparam int CALM_HI         = 650;
    localparam int HOLD_AT         = 240;
    localparam int HOLD_CYCLES     = 200;
    localparam int RAND_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 150;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int errors;
    int pending;
    int results_seen;
    int in_range_hits;
    int nearest_hits;

    int markers_sent;
    int scans_sent;
    int poses_set;

    // Robot setting in force and the last random offset, for equal-distance markers.
    int  cur_x;
    int  cur_y;
    int  cur_range;
    int  prev_ox;
    int  prev_oy;
    bit  have_prev;

    nmrb_in_if  #(.POS_BITS(POS_BITS)) marker_ch ();
    nmrb_out_if #(.POS_BITS(POS_BITS)) result_ch ();

    nearest_marker_range_bearing #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .POS_BITS     (POS_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .marker    (marker_ch.sink),
        .result    (result_ch.source)
    );

    nmrb_result_checker #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .POS_BITS     (POS_BITS),
        .CFG_W        (CFG_W)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .marker        (marker_ch),
        .result        (result_ch),
        .errors        (errors),
        .pending       (pending),
        .results_seen  (results_seen),
        .in_range_hits (in_range_hits),
        .nearest_hits  (nearest_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Run stopped: results did not arrive in time.");
        $display("FAILURE");
        $finish;
    end

    // Result side: random back-pressure, one calm stretch and one long hold-off.
    initial
    begin
        bit holdoff_done;
        holdoff_done    = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!holdoff_done && results_seen >= HOLD_AT)
            begin
                holdoff_done    = 1'b1;
                result_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (results_seen >= CALM_LO && results_seen < CALM_HI)
                result_ch.ready = 1'b1;
            else
                result_ch.ready = ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic logic signed [POS_BITS-1:0] clamp_pos(input longint v);
        if (v > POS_MAX)
            return POS_BITS'(POS_MAX);
        if (v < POS_MIN)
            return POS_BITS'(POS_MIN);
        return v[POS_BITS-1:0];
    endfunction

    // All tasks below start and end just after a falling edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_pose(
        input int                 x,
        input int                 y,
        input logic [ANGLE_W-1:0] hd,
        input int                 rng
    );
        logic [POS_BITS-1:0] xb;
        logic [POS_BITS-1:0] yb;
        logic [POS_BITS-2:0] rb;
        xb = POS_BITS'(x);
        yb = POS_BITS'(y);
        rb = (POS_BITS-1)'(rng);
        write_reg(CFG_ROBOT_X, CFG_W'(xb));
        write_reg(CFG_ROBOT_Y, CFG_W'(yb));
        write_reg(CFG_HEADING, CFG_W'(hd));
        write_reg(CFG_MAX_RANGE, CFG_W'(rb));
        cur_x     = x;
        cur_y     = y;
        cur_range = rng;
        have_prev = 1'b0;
        poses_set++;
    endtask

    task automatic send_marker(
        input logic [ID_W-1:0]            id,
        input logic signed [POS_BITS-1:0] x,
        input logic signed [POS_BITS-1:0] y,
        input logic                       last
    );
        if (!(markers_sent >= CALM_LO && markers_sent < CALM_HI))
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                marker_ch.valid = 1'b0;
                @(negedge clk);
            end
        end
        marker_ch.valid     = 1'b1;
        marker_ch.marker_id = id;
        marker_ch.marker_x  = x;
        marker_ch.marker_y  = y;
        marker_ch.scan_end  = last;
        @(posedge clk);
        while (!marker_ch.ready)
            @(posedge clk);
        @(negedge clk);
        markers_sent++;
        if (last)
            scans_sent++;
    endtask

    // Stops offering markers and waits until every result is back.
    task automatic drain();
        marker_ch.valid = 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic pick_random_pose();
        int                 x;
        int                 y;
        int                 rng;
        logic [ANGLE_W-1:0] hd;
        logic [POS_BITS-1:0] raw;
        raw = POS_BITS'($urandom);
        case ($urandom_range(5))
            0:       x = POS_MIN;
            1:       x = POS_MAX;
            default: x = int'(signed'(raw));
        endcase
        raw = POS_BITS'($urandom);
        case ($urandom_range(5))
            0:       y = POS_MIN;
            1:       y = POS_MAX;
            default: y = int'(signed'(raw));
        endcase
        case ($urandom_range(4))
            0:       hd = '0;
            1:       hd = 16'h8000;
            2:       hd = 16'h7FFF;
            default: hd = ANGLE_W'($urandom);
        endcase
        case ($urandom_range(5))
            0:       rng = 0;
            1:       rng = $urandom_range(2048);
            2:       rng = $urandom_range(1 << 16);
            3:       rng = $urandom_range(RANGE_MAX);
            4:       rng = RANGE_MAX;
            default: rng = $urandom_range(1 << 20);
        endcase
        set_pose(x, y, hd, rng);
    endtask

    // Mostly markers scattered around the robot, some at equal distance to
    // the previous one, some anywhere at all.
    task automatic random_marker(input logic last);
        int                  spread;
        int                  ox;
        int                  oy;
        int                  pick;
        logic [POS_BITS-1:0] rx;
        logic [POS_BITS-1:0] ry;
        logic signed [POS_BITS-1:0] mx;
        logic signed [POS_BITS-1:0] my;
        spread = 2 * cur_range + 64;
        pick   = $urandom_range(99);
        if (pick < 15)
        begin
            rx = POS_BITS'($urandom);
            ry = POS_BITS'($urandom);
            mx = rx;
            my = ry;
        end
        else
        begin
            if (pick < 30 && have_prev)
            begin
                ox = -prev_oy;
                oy = prev_ox;
            end
            else
            begin
                ox = int'($urandom_range(2 * spread)) - spread;
                oy = int'($urandom_range(2 * spread)) - spread;
            end
            mx = clamp_pos(longint'(cur_x) + ox);
            my = clamp_pos(longint'(cur_y) + oy);
        end
        prev_ox   = int'(mx) - cur_x;
        prev_oy   = int'(my) - cur_y;
        have_prev = 1'b1;
        send_marker(ID_W'($urandom_range(16'hFFFF)), mx, my, last);
    endtask

    task automatic random_scans(input int count);
        int left;
        int len;
        left = count;
        while (left > 0)
        begin
            len = $urandom_range(1, 12);
            if (len > left)
                len = left;
            for (int k = 0; k < len; k++)
                random_marker(k == len - 1);
            left -= len;
        end
    endtask

    initial
    begin
        markers_sent        = 0;
        scans_sent          = 0;
        poses_set           = 0;
        have_prev           = 1'b0;
        cur_x               = 0;
        cur_y               = 0;
        cur_range           = 0;
        prev_ox             = 0;
        prev_oy             = 0;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        marker_ch.valid     = 1'b0;
        marker_ch.marker_id = '0;
        marker_ch.marker_x  = '0;
        marker_ch.marker_y  = '0;
        marker_ch.scan_end  = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset settings: zero range, so only a marker on the robot counts.
        send_marker(16'h0000, 0, 0, 1'b0);
        send_marker(16'hFFFF, 5, 0, 1'b1);
        drain();

        // Robot at the origin, full range: axes, quadrants, ties, half turn.
        set_pose(0, 0, 16'h0000, RANGE_MAX);
        for (int k = int'(CFG_MAX_RANGE) + 1; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), CFG_W'($urandom));
        send_marker(16'd1, 256, 0, 1'b0);
        send_marker(16'd2, 0, 256, 1'b0);
        send_marker(16'd3, -256, 0, 1'b0);
        send_marker(16'd4, -256, 256, 1'b0);
        send_marker(16'd5, -256, -256, 1'b0);
        send_marker(16'd6, 0, -256, 1'b0);
        send_marker(16'd7, 3, 4, 1'b0);
        send_marker(16'd8, -4, 3, 1'b0);
        send_marker(16'd9, POS_BITS'(POS_MAX), POS_BITS'(POS_MIN), 1'b1);
        drain();

        // Robot in a corner, heading a half turn, zero range: widest offsets.
        set_pose(POS_MIN, POS_MAX, 16'h8000, 0);
        send_marker(16'd10, POS_BITS'(POS_MAX), POS_BITS'(POS_MIN), 1'b0);
        send_marker(16'd11, POS_BITS'(POS_MIN), POS_BITS'(POS_MAX), 1'b0);
        send_marker(16'd12, POS_BITS'(POS_MAX), POS_BITS'(POS_MAX), 1'b0);
        send_marker(16'd13, POS_BITS'(POS_MIN), POS_BITS'(POS_MIN), 1'b1);
        send_marker(16'd14, 0, 0, 1'b1);
        drain();

        // Opposite corner, full range, and a tie at the closest distance.
        set_pose(POS_MAX, POS_MIN, 16'h7FFF, RANGE_MAX);
        send_marker(16'd15, POS_BITS'(POS_MIN), POS_BITS'(POS_MAX), 1'b0);
        send_marker(16'd16, POS_BITS'(POS_MAX), POS_BITS'(POS_MIN + 1), 1'b0);
        send_marker(16'd17, POS_BITS'(POS_MAX - 1), POS_BITS'(POS_MIN), 1'b1);

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            drain();
            pick_random_pose();
            random_scans(ITEMS_PER_PHASE);
        end
        drain();

        $display("Covered %0d markers in %0d scans under %0d robot settings,",
                 markers_sent, scans_sent, poses_set);
        $display("with %0d in range and %0d scans that reported a nearest marker.",
                 in_range_hits, nearest_hits);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ nearest_marker_range_bearing.f @@
src/nmrb_pkg.sv
src/nmrb_in_if.sv
src/nmrb_out_if.sv
src/nmrb_front.sv
src/nmrb_cell.sv
src/nmrb_track.sv
src/nearest_marker_range_bearing.sv
verif/nmrb_result_checker.sv
verif/tb_nearest_marker_range_bearing.sv
